// File: design/cef_pkg.sv
// ----------------------------------------------------------------------------
// cef_pkg: shared types and constants of the 3x3 edge-clamped filter
// Geometry limits, register indexes and the job record that the front part
// hands to the back part.
// ----------------------------------------------------------------------------
package cef_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = COL_W + 1;
    localparam int ROW_W     = 17;
    localparam int POS_W     = 28;
    localparam int OIDX_W    = 27;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [FW_W-1:0] width;
        logic [15:0]     height;
    } t_geom;

    typedef struct packed {
        logic [9:0]       divisor;
        logic [2:0][23:0] kern;
    } t_coef;

    typedef struct packed {
        logic [8:0][7:0] pix;
        logic            frame_end;
    } t_job;

endpackage

// File: design/cef_pix_if.sv
// ----------------------------------------------------------------------------
// cef_pix_if: input pixel channel
// Valid/ready channel carrying one opcode and one grey pixel per beat.
// ----------------------------------------------------------------------------
interface cef_pix_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] pixel_value;

    modport source(output valid, output opcode, output pixel_value, input ready);
    modport sink(input valid, input opcode, input pixel_value, output ready);
endinterface

// File: design/cef_res_if.sv
// ----------------------------------------------------------------------------
// cef_res_if: result channel
// Valid/ready channel carrying one filtered pixel and a frame end flag.
// ----------------------------------------------------------------------------
interface cef_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_value;
    logic       frame_end;

    modport source(output valid, output filtered_value, output frame_end, input ready);
    modport sink(input valid, input filtered_value, input frame_end, output ready);
endinterface

// File: design/cef_queue.sv
// ----------------------------------------------------------------------------
// cef_queue: two-entry job queue
// Decouples the raster front part from the arithmetic back part.
// ----------------------------------------------------------------------------
module cef_queue
    import cef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("job popped from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");

endmodule

// File: design/cef_front.sv
// ----------------------------------------------------------------------------
// cef_front: raster tracking and window assembly
// Accepts pixel beats, keeps two line stores and a three-column window, and
// emits one job with the border-clamped neighborhood for each due result.
// ----------------------------------------------------------------------------
module cef_front
    import cef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cef_pix_if.sink i_pix,
    input  t_geom i_geom,
    output logic o_push,
    output t_job o_job,
    input  logic i_full
);

    typedef enum logic {S_IDLE, S_UPD} t_state;

    t_state            r_state;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [POS_W-1:0]  r_pos;
    logic [OIDX_W-1:0] r_oidx;
    logic [FW_W-1:0]   r_fw;
    logic [15:0]       r_fh;
    logic [POS_W-1:0]  r_total;
    logic [23:0]       r_win [3];
    logic [7:0]        r_v;
    logic [7:0]        r_pq;
    logic [7:0]        r_cq;
    logic [7:0]        r_mem_p [MAX_WIDTH];
    logic [7:0]        r_mem_c [MAX_WIDTH];

    logic              accept;
    logic              first;
    logic              drop;
    logic              fire;
    logic              out_ok;
    logic              e0;
    logic              e1;
    logic              top_c;
    logic              bot_c;
    logic [23:0]       col;
    logic [23:0]       lc;
    logic [23:0]       cc;
    logic [23:0]       rc;
    logic [2:0][23:0]  sel;
    logic [FW_W-1:0]   col_nx;

    assign i_pix.ready = (r_state == S_IDLE);
    assign accept = i_pix.valid && i_pix.ready;
    assign first  = (r_col == '0) && (r_row == '0);
    assign drop   = (i_pix.opcode == OP_FLUSH) && (first || (r_pos < r_total));
    assign fire   = (r_state == S_UPD) && !i_full;

    always_comb begin
        col    = {r_v, r_cq, r_pq};
        out_ok = r_pos >= (POS_W'(r_fw) + POS_W'(1));
        e0     = out_ok && (r_col == '0);
        e1     = out_ok && (r_col != '0);
        col_nx = {1'b0, r_col} + FW_W'(1);
        if (e0) begin
            lc    = (r_fw >= FW_W'(2)) ? r_win[1] : r_win[2];
            cc    = r_win[2];
            rc    = r_win[2];
            top_c = (r_row == ROW_W'(2));
            bot_c = r_row >= (ROW_W'(r_fh) + ROW_W'(1));
        end else begin
            lc    = (r_col == COL_W'(1)) ? r_win[2] : r_win[1];
            cc    = r_win[2];
            rc    = col;
            top_c = (r_row == ROW_W'(1));
            bot_c = r_row >= ROW_W'(r_fh);
        end
        sel[0] = lc;
        sel[1] = cc;
        sel[2] = rc;
        for (int k = 0; k < 3; k++) begin
            o_job.pix[k*3]   = top_c ? sel[k][15:8] : sel[k][7:0];
            o_job.pix[k*3+1] = sel[k][15:8];
            o_job.pix[k*3+2] = bot_c ? sel[k][15:8] : sel[k][23:16];
        end
        o_job.frame_end = (POS_W'(r_oidx) == (r_total - POS_W'(1)));
        o_push = fire && (e0 || e1);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pq <= r_mem_p[r_col];
            r_cq <= r_mem_c[r_col];
            r_v  <= i_pix.pixel_value;
        end
        if (fire) begin
            r_mem_p[r_col] <= r_cq;
            r_mem_c[r_col] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_oidx  <= '0;
            r_fw    <= '0;
            r_fh    <= '0;
            r_total <= '0;
            for (int k = 0; k < 3; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && !drop) begin
                        if (first) begin
                            r_fw    <= i_geom.width;
                            r_fh    <= i_geom.height;
                            r_total <= POS_W'(i_geom.width) * POS_W'(i_geom.height);
                        end
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (fire) begin
                        r_win[0] <= r_win[1];
                        r_win[1] <= r_win[2];
                        r_win[2] <= col;
                        if (r_pos >= (r_total + POS_W'(r_fw))) begin
                            r_col  <= '0;
                            r_row  <= '0;
                            r_pos  <= '0;
                            r_oidx <= '0;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                            if (e0 || e1) begin
                                r_oidx <= r_oidx + OIDX_W'(1);
                            end
                            if (col_nx >= r_fw) begin
                                r_col <= '0;
                                r_row <= r_row + ROW_W'(1);
                            end else begin
                                r_col <= col_nx[COL_W-1:0];
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/cef_back.sv
// ----------------------------------------------------------------------------
// cef_back: weighted sum, division and clamping
// Runs nine multiply-accumulate steps on one shared multiplier, a restoring
// division one quotient bit per cycle, and clamps into the output register.
// ----------------------------------------------------------------------------
module cef_back
    import cef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_empty,
    output logic o_pop,
    input  t_coef i_coef,
    cef_res_if.source o_res
);

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_PREP, S_DIV, S_OUT} t_state;

    t_state              r_state;
    t_job                r_job;
    logic [3:0]          r_step;
    logic [1:0]          r_kr;
    logic [1:0]          r_kc;
    logic signed [16:0]  r_prod;
    logic                r_pvld;
    logic signed [19:0]  r_acc;
    logic [18:0]         r_num;
    logic [9:0]          r_rem;
    logic [4:0]          r_dstep;
    logic [7:0]          r_res;
    logic                r_ov;
    logic [7:0]          r_oval;
    logic                r_ofe;

    logic [9:0]          dv;
    logic [10:0]         rem_sh;
    logic                qbit;
    logic [7:0]          wgt;
    logic [18:0]         q_fin;

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign o_res.valid          = r_ov;
    assign o_res.filtered_value = r_oval;
    assign o_res.frame_end      = r_ofe;

    always_comb begin
        dv     = (i_coef.divisor == '0) ? 10'd1 : i_coef.divisor;
        rem_sh = {r_rem, r_num[18]};
        qbit   = rem_sh >= {1'b0, dv};
        wgt    = i_coef.kern[r_kr][{r_kc, 3'b000} +: 8];
        q_fin  = {r_num[17:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pvld  <= 1'b0;
        end else begin
            if (o_res.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_step  <= '0;
                        r_kr    <= '0;
                        r_kc    <= '0;
                        r_acc   <= '0;
                        r_pvld  <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_pvld) begin
                        r_acc <= r_acc + 20'(r_prod);
                    end
                    if (r_step == 4'd9) begin
                        r_pvld  <= 1'b0;
                        r_state <= S_PREP;
                    end else begin
                        r_prod <= $signed({1'b0, r_job.pix[r_step]}) * $signed(wgt);
                        r_pvld <= 1'b1;
                        r_step <= r_step + 4'd1;
                        if (r_kr == 2'd2) begin
                            r_kr <= 2'd0;
                            r_kc <= r_kc + 2'd1;
                        end else begin
                            r_kr <= r_kr + 2'd1;
                        end
                    end
                end
                S_PREP: begin
                    if (r_acc[19] || (r_acc == '0)) begin
                        r_res   <= 8'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_num   <= r_acc[18:0];
                        r_rem   <= '0;
                        r_dstep <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= qbit ? 10'(rem_sh - {1'b0, dv}) : rem_sh[9:0];
                    r_num   <= {r_num[17:0], qbit};
                    r_dstep <= r_dstep + 5'd1;
                    if (r_dstep == 5'd18) begin
                        r_res   <= (|q_fin[18:8]) ? 8'd255 : q_fin[7:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || o_res.ready)) begin
            r_oval <= r_res;
            r_ofe  <= r_job.frame_end;
        end
    end

endmodule

// File: design/conv3x3_clamped_edge_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_clamped_edge_filter: streaming 3x3 convolution with edge clamping
//
//   channel   direction   beat contents
//   i_pix     in          opcode, pixel_value
//   o_res     out         filtered_value, frame_end
//   i_cfg_*   in          register index, 24-bit write data
//
// The front part takes a beat, then waits for room in the job queue before it
// updates its window and takes the next beat. The back part works on one job
// at a time: it takes the job, runs the shared multiplier, prepares, divides
// and loads the output register; a sum of zero or below skips the division.
// Reset is synchronous; the line stores are not cleared.
// A stalled result leaves the front part running until the queue fills.
// ----------------------------------------------------------------------------
module conv3x3_clamped_edge_filter
    import cef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cef_pix_if.sink              i_pix,
    cef_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [11:0]      r_width;
    logic [15:0]      r_height;
    t_coef            r_coef;
    t_geom            geom;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    t_job             job_in;
    t_job             job_out;

    always_comb begin
        if (r_width == '0) begin
            geom.width = FW_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            geom.width = FW_W'(MAX_WIDTH);
        end else begin
            geom.width = FW_W'(r_width);
        end
        geom.height = (r_height == '0) ? 16'd1 : r_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width        <= 12'd640;
            r_height       <= 16'd480;
            r_coef.divisor <= 10'd1;
            r_coef.kern[0] <= 24'd0;
            r_coef.kern[1] <= 24'd65536;
            r_coef.kern[2] <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width        <= i_cfg_data[11:0];
                REG_IMAGE_HEIGHT: r_height       <= i_cfg_data[15:0];
                REG_DIVISOR:      r_coef.divisor <= i_cfg_data[9:0];
                REG_KERNEL_TOP:   r_coef.kern[0] <= i_cfg_data;
                REG_KERNEL_MID:   r_coef.kern[1] <= i_cfg_data;
                REG_KERNEL_BOT:   r_coef.kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cef_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_geom  (geom),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    cef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    cef_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .i_coef  (r_coef),
        .o_res   (o_res)
    );

endmodule
